// File: src/load_cell_rolling_average_scale_macros.svh
// assertion macros used by the rolling average scale top file
`ifndef LOAD_CELL_ROLLING_AVERAGE_SCALE_MACROS_SVH
`define LOAD_CELL_ROLLING_AVERAGE_SCALE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define LCRAS_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define LCRAS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/lcras_pkg.sv
// shared types and constants of the load cell rolling average scale
package lcras_pkg;

   // field widths
   localparam int SAMPLE_W   = 24;
   localparam int TARED_W    = 25;
   localparam int WEIGHT_W   = 32;
   localparam int WIN_W      = 7;
   localparam int CAL_W      = 24;
   localparam int FRAC_SHIFT = 16;

   // shared divider sizing
   localparam int DVD_W  = TARED_W + FRAC_SHIFT;
   localparam int DVS_W  = CAL_W;
   localparam int STEP_W = 6;

   // csr map
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LENGTH      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TARE_OFFSET        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CALIBRATION_FACTOR = 2'd2;

   // reset values
   localparam logic [WIN_W-1:0]           WINDOW_RESET = 7'd16;
   localparam logic signed [SAMPLE_W-1:0] TARE_RESET   = 24'sd0;
   localparam logic [CAL_W-1:0]           CAL_RESET    = 24'd256;

   // weight clamp values
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 32'h7fff_ffff;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = 32'h8000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_WT_GO,
      ST_WT_WAIT,
      ST_PUBLISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic avg_start;
      logic avg_finish;
      logic wt_start;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic div_idle;
      logic out_free;
   } status_type;

endpackage

// File: src/lcras_ram.sv
// generic single write port ram with registered read
module lcras_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/lcras_div.sv
// shared restoring divider, one quotient bit per cycle
module lcras_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [lcras_pkg::STEP_W-1:0]     steps,
   input  logic [lcras_pkg::DVD_W-1:0]      dividend,
   input  logic [lcras_pkg::DVS_W-1:0]      divisor,
   output logic                             idle,
   output logic [lcras_pkg::DVD_W-1:0]      quotient
);

   logic [lcras_pkg::DVD_W-1:0]  quo_ff, quo_in;
   logic [lcras_pkg::DVS_W-1:0]  rem_ff, rem_in;
   logic [lcras_pkg::DVS_W-1:0]  dvs_ff;
   logic [lcras_pkg::STEP_W-1:0] cnt_ff;
   logic [lcras_pkg::DVS_W:0]    trial;
   logic [lcras_pkg::DVS_W:0]    diff;
   logic                         fits;

   // dividend is left aligned, so after the last step the quotient fills quo_ff
   always_comb begin
      trial  = {rem_ff, quo_ff[lcras_pkg::DVD_W-1]};
      fits   = trial >= {1'b0, dvs_ff};
      diff   = trial - {1'b0, dvs_ff};
      rem_in = fits ? diff[lcras_pkg::DVS_W-1:0] : trial[lcras_pkg::DVS_W-1:0];
      quo_in = {quo_ff[lcras_pkg::DVD_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= steps;
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (cnt_ff != '0) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign idle     = (cnt_ff == '0);
   assign quotient = quo_ff;

endmodule

// File: src/lcras_ctrl.sv
// sequencing state machine for one sample
module lcras_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  lcras_pkg::status_type  status,
   output lcras_pkg::cmd_type     cmd
);

   lcras_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lcras_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = lcras_pkg::ST_UPDATE;
            end
         end
         lcras_pkg::ST_UPDATE:   state_in = lcras_pkg::ST_AVG_GO;
         lcras_pkg::ST_AVG_GO:   state_in = lcras_pkg::ST_AVG_WAIT;
         lcras_pkg::ST_AVG_WAIT: begin
            if (status.div_idle) begin
               state_in = lcras_pkg::ST_WT_GO;
            end
         end
         lcras_pkg::ST_WT_GO:    state_in = lcras_pkg::ST_WT_WAIT;
         lcras_pkg::ST_WT_WAIT: begin
            if (status.div_idle) begin
               state_in = lcras_pkg::ST_PUBLISH;
            end
         end
         lcras_pkg::ST_PUBLISH: begin
            if (status.out_free) begin
               state_in = lcras_pkg::ST_IDLE;
            end
         end
         default: state_in = lcras_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         lcras_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         lcras_pkg::ST_UPDATE:   cmd.update     = 1'b1;
         lcras_pkg::ST_AVG_GO:   cmd.avg_start  = 1'b1;
         lcras_pkg::ST_AVG_WAIT: cmd.avg_finish = status.div_idle;
         lcras_pkg::ST_WT_GO:    cmd.wt_start   = 1'b1;
         lcras_pkg::ST_WT_WAIT:  ;
         lcras_pkg::ST_PUBLISH:  cmd.publish    = status.out_free;
         default:                ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcras_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/lcras_dp.sv
// datapath: sample ring, running sum, divisions and result register
module lcras_dp #(
   parameter int MAX_WINDOW = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lcras_pkg::cmd_type                     cmd,
   output lcras_pkg::status_type                  status,
   input  logic                                   restart,
   input  logic signed [lcras_pkg::SAMPLE_W-1:0]  sample,
   input  logic [lcras_pkg::WIN_W-1:0]            window_length,
   input  logic signed [lcras_pkg::SAMPLE_W-1:0]  tare_offset,
   input  logic [lcras_pkg::CAL_W-1:0]            calibration_factor,
   input  logic                                   rsp_tready,
   output logic                                   rsp_tvalid,
   output logic signed [lcras_pkg::SAMPLE_W-1:0]  raw_average,
   output logic signed [lcras_pkg::TARED_W-1:0]   tared_value,
   output logic signed [lcras_pkg::WEIGHT_W-1:0]  weight,
   output logic                                   window_full,
   output logic                                   weight_saturated
);

   localparam int IDX_W = $clog2(MAX_WINDOW);
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = lcras_pkg::SAMPLE_W + IDX_W;

   logic signed [lcras_pkg::SAMPLE_W-1:0] sample_ff;
   logic signed [SUM_W-1:0]               sum_ff, sum_in;
   logic [CNT_W-1:0]                      cnt_ff, cnt_in;
   logic [IDX_W-1:0]                      idx_ff, idx_in;
   logic [CNT_W-1:0]                      idx_plus;
   logic [CNT_W-1:0]                      eff_window;
   logic                                  full_ff;
   logic                                  sum_neg_ff;
   logic signed [lcras_pkg::SAMPLE_W-1:0] avg_ff, avg_in;
   logic signed [lcras_pkg::TARED_W-1:0]  tared_ff, tared_in;
   logic [lcras_pkg::SAMPLE_W-1:0]        old_sample;
   logic [SUM_W-1:0]                      abs_sum;
   logic [lcras_pkg::TARED_W-1:0]         abs_tared;
   logic [lcras_pkg::SAMPLE_W-1:0]        q_avg;
   logic [lcras_pkg::DVD_W-1:0]           div_dividend;
   logic [lcras_pkg::DVS_W-1:0]           div_divisor;
   logic [lcras_pkg::STEP_W-1:0]          div_steps;
   logic                                  div_idle;
   logic [lcras_pkg::DVD_W-1:0]           quotient;
   logic                                  wt_neg, wt_sat;
   logic [lcras_pkg::WEIGHT_W-1:0]        wt_mag, wt_val;
   logic                                  rsp_valid_ff;
   logic signed [lcras_pkg::SAMPLE_W-1:0] rsp_avg_ff;
   logic signed [lcras_pkg::TARED_W-1:0]  rsp_tared_ff;
   logic [lcras_pkg::WEIGHT_W-1:0]        rsp_weight_ff;
   logic                                  rsp_full_ff;
   logic                                  rsp_sat_ff;

   // zero counts as one, anything above the ring depth as the ring depth
   always_comb begin
      if (window_length == '0) begin
         eff_window = CNT_W'(1);
      end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
         eff_window = CNT_W'(MAX_WINDOW);
      end else begin
         eff_window = CNT_W'(window_length);
      end
   end

   lcras_ram #(
      .WIDTH (lcras_pkg::SAMPLE_W),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (idx_ff),
      .wr_data (sample_ff),
      .rd_en   (cmd.capture),
      .rd_addr (idx_ff),
      .rd_data (old_sample)
   );

   // running sum: grow while filling, then swap the oldest sample out
   always_comb begin
      idx_plus = CNT_W'(idx_ff) + 1'b1;
      idx_in   = (idx_plus == eff_window) ? '0 : IDX_W'(idx_plus);
      if (cnt_ff < eff_window) begin
         cnt_in = cnt_ff + 1'b1;
         sum_in = sum_ff + SUM_W'(sample_ff);
      end else begin
         cnt_in = cnt_ff;
         sum_in = sum_ff + SUM_W'(sample_ff) - SUM_W'($signed(old_sample));
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         sum_ff <= '0;
         cnt_ff <= '0;
         idx_ff <= '0;
      end else if (cmd.update) begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   // divider operands: average first, then weight
   always_comb begin
      abs_sum   = sum_ff[SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;
      abs_tared = tared_ff[lcras_pkg::TARED_W-1] ? (~tared_ff + 1'b1) : tared_ff;
      if (cmd.wt_start) begin
         div_dividend = lcras_pkg::DVD_W'(abs_tared) << lcras_pkg::FRAC_SHIFT;
         div_divisor  = (calibration_factor == '0) ? lcras_pkg::DVS_W'(1)
                                                   : calibration_factor;
         div_steps    = lcras_pkg::STEP_W'(lcras_pkg::DVD_W);
      end else begin
         div_dividend = lcras_pkg::DVD_W'(abs_sum) << (lcras_pkg::DVD_W - SUM_W);
         div_divisor  = lcras_pkg::DVS_W'(cnt_ff);
         div_steps    = lcras_pkg::STEP_W'(SUM_W);
      end
   end

   lcras_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.avg_start || cmd.wt_start),
      .steps    (div_steps),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .idle     (div_idle),
      .quotient (quotient)
   );

   // signed average and tare
   always_comb begin
      q_avg    = quotient[lcras_pkg::SAMPLE_W-1:0];
      avg_in   = sum_neg_ff ? (~q_avg + 1'b1) : q_avg;
      tared_in = lcras_pkg::TARED_W'(avg_in) - lcras_pkg::TARED_W'(tare_offset);
   end

   // weight sign and clamp
   always_comb begin
      wt_neg = tared_ff[lcras_pkg::TARED_W-1];
      wt_mag = quotient[lcras_pkg::WEIGHT_W-1:0];
      if (wt_neg) begin
         wt_sat = (|quotient[lcras_pkg::DVD_W-1:lcras_pkg::WEIGHT_W])
               || (quotient[lcras_pkg::WEIGHT_W-1] && (|quotient[lcras_pkg::WEIGHT_W-2:0]));
      end else begin
         wt_sat = |quotient[lcras_pkg::DVD_W-1:lcras_pkg::WEIGHT_W-1];
      end
      if (wt_sat) begin
         wt_val = wt_neg ? lcras_pkg::WEIGHT_MIN : lcras_pkg::WEIGHT_MAX;
      end else begin
         wt_val = wt_neg ? (~wt_mag + 1'b1) : wt_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= sample;
      end
      if (cmd.update) begin
         full_ff <= (cnt_in == eff_window);
      end
      if (cmd.avg_start) begin
         sum_neg_ff <= sum_ff[SUM_W-1];
      end
      if (cmd.avg_finish) begin
         avg_ff   <= avg_in;
         tared_ff <= tared_in;
      end
      if (cmd.publish) begin
         rsp_avg_ff    <= avg_ff;
         rsp_tared_ff  <= tared_ff;
         rsp_weight_ff <= wt_val;
         rsp_full_ff   <= full_ff;
         rsp_sat_ff    <= wt_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.div_idle = div_idle;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid       = rsp_valid_ff;
   assign raw_average      = rsp_avg_ff;
   assign tared_value      = rsp_tared_ff;
   assign weight           = rsp_weight_ff;
   assign window_full      = rsp_full_ff;
   assign weight_saturated = rsp_sat_ff;

endmodule

// File: src/load_cell_rolling_average_scale.sv
// Load cell rolling average scale: each signed 24-bit sample word on req_ goes into a
// ring of MAX_WINDOW entries and a running sum over the last window_length samples
// (zero counts as one, values above MAX_WINDOW as MAX_WINDOW). While the window fills
// the sum only grows; once full, the oldest sample is swapped out. Every sample gives
// one rsp_ word: the average (sum over samples held, truncated toward zero), the tared
// value (average minus tare_offset) and the weight in Q.8 (tared value times 65536
// over the Q16.8 calibration factor, truncated toward zero, clamped to 32 bits, with
// a flag when clamped; a zero factor acts as one). Writing window_length, even with
// the same value, empties the window. Registers: window_length at 0x0, tare_offset at
// 0x4, calibration_factor at 0x8; write them only while no sample is in flight. Both
// divisions run on one shared restoring divider, one quotient bit per cycle, and that
// sets the rate: the next sample is taken only once both divisions of the last are
// done and its word has gone into the output register. A finished word waits in the
// output register while the next sample is taken in.
`include "load_cell_rolling_average_scale_macros.svh"

module load_cell_rolling_average_scale #(
   parameter int MAX_WINDOW = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // input words
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [23:0]                         req_tdata,   // [23:0] sample
   // result words
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [23:0] raw_average, [48:24] tared_value, [80:49] weight,
   // [81] window_full, [82] weight_saturated, [87:83] zero
   output logic [87:0]                         rsp_tdata,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lcras_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [lcras_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [lcras_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   logic [lcras_pkg::WIN_W-1:0]           window_length_ff;
   logic signed [lcras_pkg::SAMPLE_W-1:0] tare_offset_ff;
   logic [lcras_pkg::CAL_W-1:0]           cal_factor_ff;
   logic [lcras_pkg::CSR_IDX_W-1:0]       csr_index;
   logic                                  csr_write;
   logic                                  restart;

   lcras_pkg::cmd_type    cmd;
   lcras_pkg::status_type status;

   logic signed [lcras_pkg::SAMPLE_W-1:0] raw_average;
   logic signed [lcras_pkg::TARED_W-1:0]  tared_value;
   logic signed [lcras_pkg::WEIGHT_W-1:0] weight;
   logic                                  window_full;
   logic                                  weight_saturated;

   // register port: zero wait states, word addressed
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[lcras_pkg::CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   // any write of the window length empties the window
   assign restart    = csr_write && (csr_index == lcras_pkg::REG_WINDOW_LENGTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= lcras_pkg::WINDOW_RESET;
         tare_offset_ff   <= lcras_pkg::TARE_RESET;
         cal_factor_ff    <= lcras_pkg::CAL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            lcras_pkg::REG_WINDOW_LENGTH:
               window_length_ff <= csr_pwdata[lcras_pkg::WIN_W-1:0];
            lcras_pkg::REG_TARE_OFFSET:
               tare_offset_ff <= csr_pwdata[lcras_pkg::SAMPLE_W-1:0];
            lcras_pkg::REG_CALIBRATION_FACTOR:
               cal_factor_ff <= csr_pwdata[lcras_pkg::CAL_W-1:0];
            default: ;  // unmapped addresses ignore writes
         endcase
      end
   end

   // read back, tare sign extended
   always_comb begin
      case (csr_index)
         lcras_pkg::REG_WINDOW_LENGTH:
            csr_prdata = lcras_pkg::CSR_DATA_W'(window_length_ff);
         lcras_pkg::REG_TARE_OFFSET:
            csr_prdata = lcras_pkg::CSR_DATA_W'(tare_offset_ff);
         lcras_pkg::REG_CALIBRATION_FACTOR:
            csr_prdata = lcras_pkg::CSR_DATA_W'(cal_factor_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   // sequencer
   lcras_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // ring, sum, shared divider and output register
   lcras_dp #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .restart            (restart),
      .sample             (req_tdata),
      .window_length      (window_length_ff),
      .tare_offset        (tare_offset_ff),
      .calibration_factor (cal_factor_ff),
      .rsp_tready         (rsp_tready),
      .rsp_tvalid         (rsp_tvalid),
      .raw_average        (raw_average),
      .tared_value        (tared_value),
      .weight             (weight),
      .window_full        (window_full),
      .weight_saturated   (weight_saturated)
   );

   // pack the result word, lowest field first
   assign rsp_tdata = {5'b0, weight_saturated, window_full, weight, tared_value, raw_average};

   // one sample at a time: after taking a word the block is busy
   `LCRAS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "input taken while a sample is still in work")

   // a clamped weight is one of the two extremes
   `LCRAS_ASSERT_NOW(a_sat_extreme, clock, reset, rsp_tvalid && weight_saturated, weight == lcras_pkg::WEIGHT_MAX || weight == lcras_pkg::WEIGHT_MIN, "saturated weight not at a limit")

   // weight carries the sign of the tared value, or is zero
   `LCRAS_ASSERT_NOW(a_weight_sign, clock, reset, rsp_tvalid, weight == '0 || weight[lcras_pkg::WEIGHT_W-1] == tared_value[lcras_pkg::TARED_W-1], "weight sign differs from tared value")

endmodule
